@@ rtl/core/rssd_pkg.sv @@
// Shared types, constants and register indexes of the RLE sprite span decoder.
package rssd_pkg;

    // Framebuffer line pitch in bytes.
    localparam int unsigned LINE_PITCH = 320;

    localparam logic [7:0] ESCAPE_CODE = 8'h7f;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SKIP_ZERO   = 3'd4;

    typedef enum logic [2:0] {
        PH_CODE  = 3'b001,
        PH_COUNT = 3'b010,
        PH_COLOR = 3'b100
    } phase_t;

    typedef struct packed {
        logic [8:0] origin_x;
        logic [7:0] origin_y;
        logic [6:0] rect_width;
        logic [6:0] rect_height;
        logic       skip_zero;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  run_count;
        logic [8:0]  column_pos;
        logic [6:0]  row_index;
        logic [15:0] row_base;
        logic        finished;
    } dec_state_t;

    typedef struct packed {
        logic [15:0] pixel_address;
        logic [7:0]  span_length;
        logic [7:0]  color_index;
        logic        write_enable;
        logic        picture_done;
    } span_t;

endpackage

@@ rtl/core/rssd_step.sv @@
// Per-byte decode step: parse phase, span emission and row/column bookkeeping.
module rssd_step (
    input  rssd_pkg::cfg_t       cfg,
    input  rssd_pkg::dec_state_t state_cur,
    input  logic                 start_flag,
    input  logic [7:0]           code_byte,
    output rssd_pkg::dec_state_t state_next,
    output rssd_pkg::span_t      span,
    output logic                 emit
);

    rssd_pkg::dec_state_t eff;
    logic [15:0] start_base;
    logic [7:0]  len;
    logic [8:0]  col_sum;
    logic [6:0]  row_inc;

    // Picture origin as a framebuffer offset, mod 2^16.
    assign start_base = 16'(({8'd0, cfg.origin_y} * 16'(rssd_pkg::LINE_PITCH))
                           + {7'd0, cfg.origin_x});

    // State as seen by this byte once a start has been applied.
    always_comb begin
        eff = state_cur;
        if (start_flag) begin
            eff.phase      = rssd_pkg::PH_CODE;
            eff.run_count  = 8'd0;
            eff.column_pos = 9'd0;
            eff.row_index  = 7'd0;
            eff.row_base   = start_base;
            eff.finished   = (cfg.rect_width == 7'd0) || (cfg.rect_height == 7'd0);
        end
    end

    always_comb begin
        state_next = eff;
        emit       = 1'b0;
        len        = 8'd0;
        if (!eff.finished) begin
            case (eff.phase)
                rssd_pkg::PH_CODE: begin
                    if (code_byte == rssd_pkg::ESCAPE_CODE) begin
                        state_next.phase = rssd_pkg::PH_COUNT;
                    end else begin
                        emit = 1'b1;
                        len  = 8'd1;
                    end
                end
                rssd_pkg::PH_COUNT: begin
                    state_next.run_count = code_byte;
                    state_next.phase     = rssd_pkg::PH_COLOR;
                end
                rssd_pkg::PH_COLOR: begin
                    state_next.phase = rssd_pkg::PH_CODE;
                    if (eff.run_count != 8'd0) begin
                        emit = 1'b1;
                        len  = eff.run_count;
                    end
                end
                default: begin
                    state_next.phase = rssd_pkg::PH_CODE;
                end
            endcase
        end

        col_sum = eff.column_pos + {1'b0, len};
        row_inc = eff.row_index + 7'd1;

        span.pixel_address = eff.row_base + {7'd0, eff.column_pos};
        span.span_length   = len;
        span.color_index   = code_byte;
        span.write_enable  = !(cfg.skip_zero && (code_byte == 8'd0));
        span.picture_done  = 1'b0;

        if (emit) begin
            if (col_sum >= {2'b00, cfg.rect_width}) begin
                state_next.column_pos = 9'd0;
                state_next.row_index  = row_inc;
                state_next.row_base   = eff.row_base + 16'(rssd_pkg::LINE_PITCH);
                if ((row_inc >= cfg.rect_height) || (row_inc == 7'd0)) begin
                    state_next.finished = 1'b1;
                    state_next.phase    = rssd_pkg::PH_CODE;
                    span.picture_done   = 1'b1;
                end
            end else begin
                state_next.column_pos = col_sum;
            end
        end
    end

endmodule

@@ rtl/core/rle_sprite_span_decoder_top.sv @@
// Top level of the RLE sprite span decoder: handshakes, config registers, state.
//
// Decodes an escape-byte run-length sprite stream, one byte per item, into
// pixel-span write commands for a linear framebuffer with a 320-byte line
// pitch. Byte 0x7f starts a run (count byte, then color byte); any other byte
// is a single literal pixel. A byte with s_start_flag set restarts the
// picture at the origin given by origin_x/origin_y (sampled at that byte);
// rect_width, rect_height and skip_zero are read live. Until a start byte
// arrives, and after the last row completes, bytes are consumed and dropped.
// Throughput is one byte per cycle while s_ready is high; a byte passes an input
// register, then the decode logic writes the span into the result register,
// which holds it on m_* until it is taken. The
// result register parts the two sides: decoding continues while a span waits
// as long as the next byte produces no span, and s_ready drops only when a
// span is ready to be written and the previous one is still pending.
// Configuration writes are taken at any time but must only be issued while
// the decoder is idle.
module rle_sprite_span_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,

    // compressed byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_flag,
    input  logic [7:0]  s_code_byte,

    // span commands
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_address,
    output logic [7:0]  m_span_length,
    output logic [7:0]  m_color_index,
    output logic        m_write_enable,
    output logic        m_picture_done
);

    rssd_pkg::cfg_t       cfg_reg;

    // input stage
    logic                 in_valid_reg;
    logic                 in_start_reg;
    logic [7:0]           in_byte_reg;

    // decoder state
    rssd_pkg::dec_state_t state_reg;
    rssd_pkg::dec_state_t state_next;

    // result stage
    logic                 out_valid_reg;
    rssd_pkg::span_t      out_span_reg;

    rssd_pkg::span_t      span;
    logic                 emit;
    logic                 out_free;
    logic                 advance;

    // The held byte may proceed unless it makes a span and the result
    // register is still occupied.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_ready  = !in_valid_reg || advance;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rssd_pkg::REG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_wdata;
                rssd_pkg::REG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_wdata[7:0];
                rssd_pkg::REG_RECT_WIDTH:  cfg_reg.rect_width  <= cfg_wdata[6:0];
                rssd_pkg::REG_RECT_HEIGHT: cfg_reg.rect_height <= cfg_wdata[6:0];
                rssd_pkg::REG_SKIP_ZERO:   cfg_reg.skip_zero   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Input register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_start_reg <= s_start_flag;
            in_byte_reg  <= s_code_byte;
        end
    end

    //------------------------------------------------------------------
    // Decode step
    //------------------------------------------------------------------
    rssd_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .start_flag (in_start_reg),
        .code_byte  (in_byte_reg),
        .state_next (state_next),
        .span       (span),
        .emit       (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= rssd_pkg::PH_CODE;
            state_reg.run_count  <= 8'd0;
            state_reg.column_pos <= 9'd0;
            state_reg.row_index  <= 7'd0;
            state_reg.row_base   <= 16'd0;
            state_reg.finished   <= 1'b1;   // idle until a start byte
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    //------------------------------------------------------------------
    // Result register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_span_reg <= span;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_address = out_span_reg.pixel_address;
    assign m_span_length   = out_span_reg.span_length;
    assign m_color_index   = out_span_reg.color_index;
    assign m_write_enable  = out_span_reg.write_enable;
    assign m_picture_done  = out_span_reg.picture_done;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // Out of reset the decoder waits for a start byte.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> state_reg.finished)
        else $error("decoder not idle after reset");

    // A span closing the last row leaves the decoder idle.
    a_done_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && span.picture_done) |=> state_reg.finished)
        else $error("picture_done without entering idle");

    // No span while idle unless the byte restarts the picture.
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && state_reg.finished && !in_start_reg) |-> !emit)
        else $error("span emitted while idle");

    // Zero-length runs never reach the output.
    a_nonzero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_span_length != 8'd0))
        else $error("zero-length span emitted");

    // A produced span is never dropped by the result register.
    a_span_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> out_valid_reg)
        else $error("span lost at result register");

endmodule

@@ tb/rssd_span_scoreboard_pkg.sv @@
// Span predictor and scoreboard class for the RLE sprite span decoder bench.
`timescale 1ns / 100ps

package rssd_span_scoreboard_pkg;

    import rssd_pkg::*;

    class span_scoreboard;

        cfg_t        regs;
        phase_t      phase;
        logic [7:0]  run_count;
        logic [8:0]  column_pos;
        logic [6:0]  row_index;
        logic [15:0] row_base;
        bit          finished;

        span_t       expected_spans[$];
        int          errors;
        int          spans_checked;
        int          pictures_done;

        function new();
            regs          = '0;
            phase         = PH_CODE;
            run_count     = '0;
            column_pos    = '0;
            row_index     = '0;
            row_base      = '0;
            finished      = 1'b1;
            errors        = 0;
            spans_checked = 0;
            pictures_done = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [8:0] data);
            case (index)
                REG_ORIGIN_X:    regs.origin_x    = data;
                REG_ORIGIN_Y:    regs.origin_y    = data[7:0];
                REG_RECT_WIDTH:  regs.rect_width  = data[6:0];
                REG_RECT_HEIGHT: regs.rect_height = data[6:0];
                REG_SKIP_ZERO:   regs.skip_zero   = data[0];
                default: ;
            endcase
        endfunction

        function bit picture_idle();
            return finished;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        local function void emit_span(logic [7:0] len, logic [7:0] color);
            span_t s;
            s.pixel_address = row_base + {7'd0, column_pos};
            s.span_length   = len;
            s.color_index   = color;
            s.write_enable  = !(regs.skip_zero && color == 8'h00);
            s.picture_done  = 1'b0;
            column_pos = column_pos + {1'b0, len};
            // width and height are live, so >= also catches a lowered size
            if (column_pos >= {2'b00, regs.rect_width}) begin
                column_pos = '0;
                row_index  = row_index + 7'd1;
                row_base   = row_base + 16'(LINE_PITCH);
                if (row_index >= regs.rect_height || row_index == 7'd0) begin
                    finished       = 1'b1;
                    phase          = PH_CODE;
                    s.picture_done = 1'b1;
                end
            end
            expected_spans.push_back(s);
        endfunction

        // Advances the decoder state by one accepted byte; 1 if it was decoded.
        function bit note_byte(bit start, logic [7:0] code);
            if (start) begin
                phase      = PH_CODE;
                run_count  = '0;
                column_pos = '0;
                row_index  = '0;
                row_base   = 16'(regs.origin_y * LINE_PITCH + regs.origin_x);
                finished   = (regs.rect_width == 0 || regs.rect_height == 0);
            end
            if (finished)
                return 1'b0;
            case (phase)
                PH_CODE: begin
                    if (code == ESCAPE_CODE)
                        phase = PH_COUNT;
                    else
                        emit_span(8'd1, code);
                end
                PH_COUNT: begin
                    run_count = code;
                    phase     = PH_COLOR;
                end
                default: begin
                    phase = PH_CODE;
                    if (run_count != 0)
                        emit_span(run_count, code);
                end
            endcase
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("span %0d %s got %0d expected %0d",
                                          spans_checked, name, got, want));
        endtask

        task check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0) begin
                report_mismatch($sformatf("unexpected span addr %0d len %0d",
                                          got.pixel_address, got.span_length));
                return;
            end
            want = expected_spans.pop_front();
            compare_field("pixel_address", got.pixel_address, want.pixel_address);
            compare_field("span_length", got.span_length, want.span_length);
            compare_field("color_index", got.color_index, want.color_index);
            compare_field("write_enable", got.write_enable, want.write_enable);
            compare_field("picture_done", got.picture_done, want.picture_done);
            if (want.picture_done)
                pictures_done++;
            spans_checked++;
        endtask

        task report_leftovers();
            span_t want;
            while (expected_spans.size() > 0) begin
                want = expected_spans.pop_front();
                report_mismatch($sformatf("missing span addr %0d len %0d",
                                          want.pixel_address, want.span_length));
            end
        endtask

    endclass

endpackage

@@ tb/tb_rle_sprite_span_decoder_top.sv @@
// Self-checking testbench of the RLE sprite span decoder top level.
`timescale 1ns / 100ps

module tb_rle_sprite_span_decoder_top;

    import rssd_pkg::*;
    import rssd_span_scoreboard_pkg::*;

    localparam int RANDOM_PHASES   = 12;
    localparam int BYTES_PER_PHASE = 111;
    // a byte passes the input and result registers to m_*; allow ample slack
    localparam int DRAIN_CYCLES    = 8;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_start_flag;
    logic [7:0]  s_code_byte;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_pixel_address;
    logic [7:0]  m_span_length;
    logic [7:0]  m_color_index;
    logic        m_write_enable;
    logic        m_picture_done;

    span_scoreboard span_board;

    // idling percentages, changed per phase
    int sender_idle_pct;
    int receiver_stall_pct;

    int bytes_sent;
    int bytes_decoded;
    int settings_used;

    rle_sprite_span_decoder_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_flag    (s_start_flag),
        .s_code_byte     (s_code_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_span_length   (m_span_length),
        .m_color_index   (m_color_index),
        .m_write_enable  (m_write_enable),
        .m_picture_done  (m_picture_done)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run (~1400 bytes, each with
    // sender gaps, receiver stalls and config drains).
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Span sink: values read right after the edge are the ones the flops
    // saw, so a span is taken when m_valid and m_ready were both high.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            span_board.check_span({m_pixel_address, m_span_length, m_color_index,
                                   m_write_enable, m_picture_done});
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Sends a byte item. Called just after aclk rises; valid stays high from
    // the previous item unless a random gap is inserted first.
    task automatic send_byte(input bit start, input logic [7:0] code);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_flag <= start;
        s_code_byte  <= code;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
        bytes_decoded += span_board.note_byte(start, code);
    endtask

    task automatic send_run(input logic [7:0] count, input logic [7:0] color);
        send_byte(1'b0, ESCAPE_CODE);
        send_byte(1'b0, count);
        send_byte(1'b0, color);
    endtask

    // Stop sending and let every span come out, plus slack for bytes still
    // in flight that make no span, before touching the registers.
    task automatic drain();
        s_valid <= 1'b0;
        while (span_board.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input cfg_t setting);
        logic [8:0] values [5];
        logic [2:0] indexes [5];
        values  = '{setting.origin_x, {1'b0, setting.origin_y},
                    {2'b00, setting.rect_width}, {2'b00, setting.rect_height},
                    {8'd0, setting.skip_zero}};
        indexes = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_RECT_WIDTH,
                    REG_RECT_HEIGHT, REG_SKIP_ZERO};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= indexes[i];
            cfg_wdata <= values[i];
            @(posedge aclk);
            span_board.write_register(indexes[i], values[i]);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // One random token: mostly well-formed literals and runs inside a
    // picture, a few broken runs and raw bytes, and starts once idle.
    task automatic random_token();
        int pick;
        logic [7:0] value;
        logic [7:0] count;
        pick = $urandom_range(99);
        if (span_board.picture_idle()) begin
            // noise while idle is dropped; otherwise begin a new picture
            send_byte(pick >= 10, 8'($urandom));
        end else if (pick < 55) begin
            value = ($urandom_range(6) == 0) ? 8'h00 : 8'($urandom);
            if (value == ESCAPE_CODE)
                value = 8'h00;
            send_byte(1'b0, value);
        end else if (pick < 90) begin
            case ($urandom_range(9))
                0:       count = 8'd0;
                1:       count = 8'd255;
                default: count = 8'($urandom_range(1, 16));
            endcase
            value = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
            send_run(count, value);
        end else if (pick < 95) begin
            // run cut short by a restart
            send_byte(1'b0, ESCAPE_CODE);
            if ($urandom_range(1))
                send_byte(1'b0, 8'($urandom));
            send_byte(1'b1, 8'($urandom));
        end else begin
            send_byte(1'b0, 8'($urandom));
        end
    endtask

    initial begin
        cfg_t setting;
        int   phase_sent;

        span_board         = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        bytes_sent         = 0;
        bytes_decoded      = 0;
        settings_used      = 0;

        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_ORIGIN_X;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_start_flag <= 1'b0;
        s_code_byte  <= '0;
        m_ready      <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, no idling ----
        // idle after reset: byte without start is dropped
        send_byte(1'b0, 8'h12);
        // registers still zero: start on an empty rectangle completes at once
        send_byte(1'b1, 8'h05);
        drain();

        // far corner origin, one pixel per row, six rows, zero transparent
        setting = '{origin_x: 9'd319, origin_y: 8'd199, rect_width: 7'd1,
                    rect_height: 7'd6, skip_zero: 1'b1};
        configure(setting);
        send_byte(1'b1, 8'h00);      // transparent literal
        send_byte(1'b0, 8'hff);
        send_run(8'd0, 8'h33);       // zero-length run: nothing out
        send_run(8'd255, ESCAPE_CODE); // longest run overruns the row
        send_run(8'h7f, 8'h00);      // escape value as count, transparent
        send_byte(1'b0, ESCAPE_CODE);
        send_byte(1'b0, 8'h02);
        send_byte(1'b1, 8'h01);      // restart aborts the pending run
        // five more rows; the last one wraps the address past 65535
        send_byte(1'b0, 8'h7e);
        send_byte(1'b0, 8'h80);
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'h40);
        send_byte(1'b0, 8'hfe);      // completes the picture
        send_byte(1'b0, 8'h11);      // after the last row: dropped
        drain();

        // ---- random part ----
        // Pictures left open at the end of a phase carry over into the next
        // setting, so a smaller size hits rows already past it.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
            endcase

            if (p == 0) begin
                setting = '{origin_x: 9'd0, origin_y: 8'd0, rect_width: 7'd127,
                            rect_height: 7'd127, skip_zero: 1'b0};
            end else begin
                case ($urandom_range(2))
                    0:       setting.origin_x = 9'd0;
                    1:       setting.origin_x = 9'd319;
                    default: setting.origin_x = 9'($urandom_range(319));
                endcase
                case ($urandom_range(2))
                    0:       setting.origin_y = 8'd0;
                    1:       setting.origin_y = 8'd199;
                    default: setting.origin_y = 8'($urandom_range(199));
                endcase
                case ($urandom_range(11))
                    0:       setting.rect_width = 7'd0;
                    1:       setting.rect_width = 7'd127;
                    default: setting.rect_width = 7'($urandom_range(1, 12));
                endcase
                case ($urandom_range(11))
                    0:       setting.rect_height = 7'd0;
                    1:       setting.rect_height = 7'd127;
                    default: setting.rect_height = 7'($urandom_range(1, 6));
                endcase
                setting.skip_zero = 1'($urandom_range(1));
            end
            configure(setting);

            // fixed byte budget per phase, dropped bytes included
            phase_sent = bytes_sent;
            while (bytes_sent - phase_sent < BYTES_PER_PHASE)
                random_token();
            drain();
        end

        span_board.report_leftovers();
        $display("sent %0d bytes (%0d decoded) across %0d register settings",
                 bytes_sent, bytes_decoded, settings_used);
        $display("checked %0d spans, %0d pictures completed, %0d mismatches",
                 span_board.spans_checked, span_board.pictures_done,
                 span_board.errors);
        if (span_board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
